@@ hw/rtl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the two-wire EEPROM byte master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam logic [7:0] CTRL_WRITE = 8'hA0;
    localparam logic [7:0] CTRL_READ  = 8'hA1;
    localparam logic [3:0] BYTE_BITS  = 4'd8;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic CFG_ACK_WAIT_LIMIT     = 1'b0;
    localparam logic CFG_WRITE_SETTLE_TICKS = 1'b1;

    localparam logic [7:0]  ACK_WAIT_LIMIT_RST     = 8'd250;
    localparam logic [15:0] WRITE_SETTLE_TICKS_RST = 16'd60;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic       start_wr;
        logic       start_rd;
        logic [2:0] page;
        logic [7:0] address;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte_out;
        logic       no_ack;
    } result_t;

    typedef struct packed {
        logic [7:0]  ack_wait_limit;
        logic [15:0] write_settle_ticks;
    } cfg_t;

endpackage

@@ hw/rtl/i2cm_front.sv @@
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts input items, decodes the command and queues them for the engine.
// ----------------------------------------------------------------------------
module i2cm_front
    import i2cm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [IN_USER_W-1:0] s_tuser,
    output logic                 q_valid,
    output item_t                q_item,
    input  logic                 q_pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t           queue_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    item_t           in_item;
    logic            push;
    logic            pop;

    always_comb
    begin
        in_item.start_wr   = (s_tuser == CMD_WRITE);
        in_item.start_rd   = (s_tuser == CMD_READ);
        in_item.page       = s_tdata[2:0];
        in_item.address    = s_tdata[10:3];
        in_item.write_data = s_tdata[18:11];
        in_item.sda_in     = s_tdata[19];
    end

    assign s_tready = (count_reg != CW'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ hw/rtl/i2cm_engine.sv @@
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: steps the two-wire timing once per queued item and holds
// each result in an output register.
// ----------------------------------------------------------------------------
module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_valid,
    input  item_t   q_item,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    typedef enum logic [15:0] {
        S_IDLE      = 16'h0001,
        S_ST_HIGH   = 16'h0002,
        S_ST_FALL   = 16'h0004,
        S_TX_LOW    = 16'h0008,
        S_TX_HIGH   = 16'h0010,
        S_ACK_LOW   = 16'h0020,
        S_ACK_HIGH  = 16'h0040,
        S_RX_LOW    = 16'h0080,
        S_RX_HIGH   = 16'h0100,
        S_NACK_LOW  = 16'h0200,
        S_NACK_HIGH = 16'h0400,
        S_SP_LOW    = 16'h0800,
        S_SP_HIGH   = 16'h1000,
        S_SP_RISE   = 16'h2000,
        S_SETTLE    = 16'h4000,
        S_ST_LOW    = 16'h8000
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  byte_no_reg, byte_no_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] wait_count_reg, wait_count_next;
    logic        op_read_reg, op_read_next;
    logic [2:0]  page_reg, page_next;
    logic [7:0]  address_reg, address_next;
    logic [7:0]  data_reg, data_next;
    logic        ack_missing_reg, ack_missing_next;
    logic        out_valid_reg;
    result_t     out_data_reg;

    logic        fire;
    logic        scl;
    logic        sda;
    logic        busy;
    logic        done;
    logic [3:0]  bit_inc;
    logic [15:0] wait_inc;
    result_t     result;

    assign fire      = q_valid && (!out_valid_reg || out_ready);
    assign q_pop     = fire;
    assign bit_inc   = bit_index_reg + 1'b1;
    assign wait_inc  = wait_count_reg + 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next       = state_reg;
        byte_no_next     = byte_no_reg;
        bit_index_next   = bit_index_reg;
        shift_next       = shift_reg;
        wait_count_next  = wait_count_reg;
        op_read_next     = op_read_reg;
        page_next        = page_reg;
        address_next     = address_reg;
        data_next        = data_reg;
        ack_missing_next = ack_missing_reg;
        scl              = 1'b1;
        sda              = 1'b1;
        busy             = 1'b1;
        done             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_item.start_wr || q_item.start_rd)
                begin
                    op_read_next     = q_item.start_rd;
                    page_next        = q_item.page;
                    address_next     = q_item.address;
                    data_next        = q_item.write_data;
                    ack_missing_next = 1'b0;
                    shift_next       = '0;
                    wait_count_next  = '0;
                    bit_index_next   = '0;
                    byte_no_next     = 2'd0;
                    scl              = 1'b0;
                    state_next       = S_ST_HIGH;
                end
                else
                begin
                    busy = 1'b0;
                end
            end
            S_ST_LOW:
            begin
                scl        = 1'b0;
                state_next = S_ST_HIGH;
            end
            S_ST_HIGH:
            begin
                state_next = S_ST_FALL;
            end
            S_ST_FALL:
            begin
                sda            = 1'b0;
                shift_next     = ((byte_no_reg == 2'd0) ? CTRL_WRITE : CTRL_READ)
                                 | {4'b0, page_reg, 1'b0};
                bit_index_next = '0;
                state_next     = S_TX_LOW;
            end
            S_TX_LOW:
            begin
                scl        = 1'b0;
                sda        = shift_reg[7];
                state_next = S_TX_HIGH;
            end
            S_TX_HIGH:
            begin
                sda            = shift_reg[7];
                shift_next     = {shift_reg[6:0], 1'b0};
                bit_index_next = bit_inc;
                state_next     = (bit_inc >= BYTE_BITS) ? S_ACK_LOW : S_TX_LOW;
            end
            S_ACK_LOW:
            begin
                scl             = 1'b0;
                wait_count_next = '0;
                state_next      = S_ACK_HIGH;
            end
            S_ACK_HIGH:
            begin
                if (!q_item.sda_in || (wait_inc >= {8'b0, cfg.ack_wait_limit}))
                begin
                    if (q_item.sda_in)
                    begin
                        ack_missing_next = 1'b1;
                    end
                    priority if (byte_no_reg == 2'd0)
                    begin
                        shift_next     = address_reg;
                        bit_index_next = '0;
                        byte_no_next   = 2'd1;
                        state_next     = S_TX_LOW;
                    end
                    else if (byte_no_reg == 2'd1 && op_read_reg)
                    begin
                        byte_no_next = 2'd2;
                        state_next   = S_ST_LOW;
                    end
                    else if (byte_no_reg == 2'd1)
                    begin
                        shift_next     = data_reg;
                        bit_index_next = '0;
                        byte_no_next   = 2'd2;
                        state_next     = S_TX_LOW;
                    end
                    else if (byte_no_reg == 2'd2 && op_read_reg)
                    begin
                        shift_next     = '0;
                        bit_index_next = '0;
                        byte_no_next   = 2'd3;
                        state_next     = S_RX_LOW;
                    end
                    else
                    begin
                        state_next = S_SP_LOW;
                    end
                end
                if (q_item.sda_in)
                begin
                    wait_count_next = wait_inc;
                end
            end
            S_RX_LOW:
            begin
                scl        = 1'b0;
                state_next = S_RX_HIGH;
            end
            S_RX_HIGH:
            begin
                shift_next     = {shift_reg[6:0], q_item.sda_in};
                bit_index_next = bit_inc;
                state_next     = (bit_inc >= BYTE_BITS) ? S_NACK_LOW : S_RX_LOW;
            end
            S_NACK_LOW:
            begin
                scl        = 1'b0;
                state_next = S_NACK_HIGH;
            end
            S_NACK_HIGH:
            begin
                state_next = S_SP_LOW;
            end
            S_SP_LOW:
            begin
                scl        = 1'b0;
                sda        = 1'b0;
                state_next = S_SP_HIGH;
            end
            S_SP_HIGH:
            begin
                sda        = 1'b0;
                state_next = S_SP_RISE;
            end
            S_SP_RISE:
            begin
                if (op_read_reg || (cfg.write_settle_ticks == '0))
                begin
                    done         = 1'b1;
                    byte_no_next = 2'd0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    wait_count_next = '0;
                    state_next      = S_SETTLE;
                end
            end
            S_SETTLE:
            begin
                wait_count_next = wait_inc;
                if (wait_inc >= cfg.write_settle_ticks)
                begin
                    done         = 1'b1;
                    byte_no_next = 2'd0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                busy         = 1'b0;
                byte_no_next = 2'd0;
                state_next   = S_IDLE;
            end
        endcase

        result.scl_level     = scl;
        result.sda_drive     = sda;
        result.busy_res      = busy;
        result.done_res      = done;
        result.read_byte_out = (done && op_read_reg) ? shift_reg : 8'd0;
        result.no_ack        = ack_missing_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            byte_no_reg     <= '0;
            bit_index_reg   <= '0;
            shift_reg       <= '0;
            wait_count_reg  <= '0;
            op_read_reg     <= 1'b0;
            page_reg        <= '0;
            address_reg     <= '0;
            data_reg        <= '0;
            ack_missing_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                state_reg       <= state_next;
                byte_no_reg     <= byte_no_next;
                bit_index_reg   <= bit_index_next;
                shift_reg       <= shift_next;
                wait_count_reg  <= wait_count_next;
                op_read_reg     <= op_read_next;
                page_reg        <= page_next;
                address_reg     <= address_next;
                data_reg        <= data_next;
                ack_missing_reg <= ack_missing_next;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

endmodule

@@ hw/rtl/i2c_eeprom_byte_master_core.sv @@
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master_core
// Two-wire bus master for random byte write and read of a small EEPROM.
// ----------------------------------------------------------------------------
// Each input item is one half-bit tick of bus timing. The slave channel
// carries the command in s_tuser and the page, address, write data and
// sampled SDA level in s_tdata. Every item yields exactly one result item
// on the master channel: the SCL and SDA levels for that tick, busy, done,
// the received byte on the done tick of a read, and the no-acknowledge flag.
// A command is taken only while the sequencer is idle; otherwise the item
// counts as a plain tick.
// An accepted item is registered in the input queue and its result in the
// output register. One item per cycle is sustained while the receiver
// keeps m_tready high.
// When the receiver stalls, the result holds in the output register, the
// input queue of QUEUE_DEPTH items fills, and s_tready falls once it is full.
// Reset empties the queue and output register, puts the sequencer in idle
// and loads the poll limit of 250 and the settle time of 60 ticks.
// Configuration writes through cfg_wr_en take effect at the next edge.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_master_core
    import i2cm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [15:0]           cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // page[2:0], address[10:3], write_data[18:11], sda_in[19], zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // scl_level[0], sda_drive[1], busy_res[2], done_res[3],
    // read_byte_out[11:4], no_ack[12], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata
);

    cfg_t    cfg_reg;
    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_wait_limit     <= ACK_WAIT_LIMIT_RST;
            cfg_reg.write_settle_ticks <= WRITE_SETTLE_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ACK_WAIT_LIMIT:     cfg_reg.ack_wait_limit     <= cfg_wdata[7:0];
                CFG_WRITE_SETTLE_TICKS: cfg_reg.write_settle_ticks <= cfg_wdata;
                default:                cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    i2cm_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    i2cm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tdata = {3'b000, result.no_ack, result.read_byte_out, result.done_res,
                      result.busy_res, result.sda_drive, result.scl_level};

endmodule

@@ hw/rtl/i2cm_checker.sv @@
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the result channel of the byte master.
// ----------------------------------------------------------------------------
module i2cm_checker
    import i2cm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result item changed while stalled.");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2])
        else $error("Done shown without busy.");

    a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[1:0] == 2'b11)
        else $error("Bus lines not released while idle.");

    a_byte_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[3] |-> m_tdata[11:4] == 8'd0)
        else $error("Read byte shown outside a done tick.");

endmodule

bind i2c_eeprom_byte_master_core i2cm_checker u_i2cm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
